@@ rtl/moetk_pkg.sv @@
`default_nettype none
package moetk_pkg;

   localparam int CFG_W      = 7;
   localparam int PROB_W     = 17;
   localparam int IDX_W      = 6;
   localparam int LOSS_W     = 23;
   localparam int SUM_W      = 29;
   localparam int PROD_W     = CFG_W + SUM_W;
   localparam int LIST_DEPTH = 64;
   localparam int CSR_IDX_W  = 1;

   localparam logic [PROB_W-1:0] ONE_Q16  = PROB_W'(65536);
   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
   localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_EXPERTS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_K       = 1'b1;

   localparam logic KIND_PROB = 1'b0;
   localparam logic KIND_EOB  = 1'b1;

   localparam logic RES_GATE = 1'b0;
   localparam logic RES_LOSS = 1'b1;

   typedef struct packed {
      logic [PROB_W-1:0] prob;
      logic [IDX_W-1:0]  idx;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EMIT,
      S_DSTART,
      S_DIV,
      S_LOSS
   } state_type;

   typedef struct packed {
      logic insert;
      logic mul;
      logic div_start;
      logic emit_load;
      logic loss_load;
   } cmd_type;

   typedef struct packed {
      logic token_done;
      logic emit_last;
      logic out_free;
      logic div_busy;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/moetk_if.sv @@
`default_nettype none
interface moetk_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [moetk_pkg::PROB_W-1:0]    probability;

   modport source (output valid, output kind, output probability, input ready);
   modport sink   (input valid, input kind, input probability, output ready);
endinterface

interface moetk_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            result_kind;
   logic [moetk_pkg::IDX_W-1:0]     expert_index;
   logic [moetk_pkg::PROB_W-1:0]    gate_value;
   logic [moetk_pkg::LOSS_W-1:0]    balance_loss;
   logic                            last;

   modport source (output valid, output result_kind, output expert_index,
                   output gate_value, output balance_loss, output last, input ready);
   modport sink   (input valid, input result_kind, input expert_index,
                   input gate_value, input balance_loss, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/moetk_div.sv @@
`default_nettype none
module moetk_div #(
   parameter int NW = 36,
   parameter int DW = 13
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               busy,
   output logic [NW-1:0]      quotient
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   shifted;
   logic          take;

   always_comb begin
      shifted = {r_ff, q_ff[NW-1]};
      take    = (shifted >= {1'b0, divisor});
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[NW-2:0], take};
         r_in   = take ? DW'(shifted - {1'b0, divisor}) : shifted[DW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

@@ rtl/moetk_dp.sv @@
`default_nettype none
module moetk_dp #(
   parameter int MAX_EXPERTS = 64,
   parameter int MAX_TOKENS  = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [moetk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [moetk_pkg::CFG_W-1:0]          csr_wdata,
   input  wire logic [moetk_pkg::PROB_W-1:0]         req_probability,
   input  wire moetk_pkg::cmd_type                   cmd,
   output moetk_pkg::status_type                     st,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_valid,
   output logic                                      rsp_result_kind,
   output logic [moetk_pkg::IDX_W-1:0]               rsp_expert_index,
   output logic [moetk_pkg::PROB_W-1:0]              rsp_gate_value,
   output logic [moetk_pkg::LOSS_W-1:0]              rsp_balance_loss,
   output logic                                      rsp_last
);

   localparam int CW    = moetk_pkg::CFG_W;
   localparam int PW    = moetk_pkg::PROB_W;
   localparam int SW    = moetk_pkg::SUM_W;
   localparam int NW    = moetk_pkg::PROD_W;
   localparam int LW    = moetk_pkg::LOSS_W;
   localparam int DEPTH = moetk_pkg::LIST_DEPTH;
   localparam int TW    = $clog2(MAX_TOKENS + 1);
   localparam int ECAP  = (MAX_EXPERTS < 127) ? MAX_EXPERTS : 127;

   logic [CW-1:0]         num_ff, num_in;
   logic [CW-1:0]         topk_ff, topk_in;
   logic [CW-1:0]         ecount_ff, ecount_in;
   logic [TW-1:0]         tcount_ff, tcount_in;
   logic [SW-1:0]         gsum_ff, gsum_in;
   logic [CW-1:0]         ecnt_ff, ecnt_in;
   logic                  acc_ff, acc_in;
   logic [NW-1:0]         prod_ff;
   moetk_pkg::entry_type  list_ff [DEPTH];
   moetk_pkg::entry_type  list_in [DEPTH];
   logic                  rvalid_ff, rvalid_in;
   logic                  rkind_ff;
   logic [moetk_pkg::IDX_W-1:0] ridx_ff;
   logic [PW-1:0]         rgate_ff;
   logic [LW-1:0]         rloss_ff;
   logic                  rlast_ff;

   logic [CW-1:0]         e_eff, k_eff, len;
   logic [PW-1:0]         p_sat;
   logic [DEPTH-1:0]      ge;
   moetk_pkg::entry_type  fresh;
   logic [SW:0]           sum_wide;
   logic [NW-1:0]         quotient;
   logic                  div_busy;
   logic [LW-1:0]         loss;
   logic                  tok_room;

   always_comb begin
      if (num_ff < CW'(2)) begin
         e_eff = CW'(2);
      end else if (num_ff > CW'(ECAP)) begin
         e_eff = CW'(ECAP);
      end else begin
         e_eff = num_ff;
      end
      if (topk_ff < CW'(1)) begin
         k_eff = CW'(1);
      end else if (topk_ff > e_eff) begin
         k_eff = e_eff;
      end else begin
         k_eff = topk_ff;
      end
      if (k_eff > CW'(DEPTH)) begin
         k_eff = CW'(DEPTH);
      end
      len   = (ecount_ff < k_eff) ? ecount_ff : k_eff;
      p_sat = (req_probability > moetk_pkg::ONE_Q16) ? moetk_pkg::ONE_Q16 : req_probability;
      fresh.prob = p_sat;
      fresh.idx  = ecount_ff[moetk_pkg::IDX_W-1:0];
   end

   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         ge[j] = (CW'(j) < len) && (list_ff[j].prob >= p_sat);
      end
   end

   // insert: keep, take the new entry, or shift down; emit: shift up
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         list_in[j] = list_ff[j];
      end
      if (cmd.insert) begin
         if (!ge[0]) begin
            list_in[0] = fresh;
         end
         for (int j = 1; j < DEPTH; j++) begin
            if (!ge[j]) begin
               list_in[j] = ge[j-1] ? fresh : list_ff[j-1];
            end
         end
      end else if (cmd.emit_load) begin
         for (int j = 0; j < DEPTH - 1; j++) begin
            list_in[j] = list_ff[j+1];
         end
      end
   end

   assign tok_room = (tcount_ff < TW'(MAX_TOKENS));
   assign sum_wide = {1'b0, gsum_ff} + (SW+1)'(list_ff[0].prob);

   always_comb begin
      if (tcount_ff == '0) begin
         loss = '0;
      end else if (quotient > NW'(moetk_pkg::LOSS_MAX)) begin
         loss = moetk_pkg::LOSS_MAX;
      end else begin
         loss = quotient[LW-1:0];
      end
   end

   always_comb begin
      num_in    = num_ff;
      topk_in   = topk_ff;
      ecount_in = ecount_ff;
      tcount_in = tcount_ff;
      gsum_in   = gsum_ff;
      ecnt_in   = ecnt_ff;
      acc_in    = acc_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      if (csr_we) begin
         ecount_in = '0;
         case (csr_index)
            moetk_pkg::CSR_NUM_EXPERTS: num_in  = csr_wdata;
            moetk_pkg::CSR_TOP_K:       topk_in = csr_wdata;
            default: ;
         endcase
      end
      if (cmd.insert) begin
         if (st.token_done) begin
            ecount_in = '0;
            ecnt_in   = '0;
            acc_in    = tok_room;
            if (tok_room) begin
               tcount_in = tcount_ff + 1'b1;
            end
         end else begin
            ecount_in = ecount_ff + 1'b1;
         end
      end
      if (cmd.emit_load) begin
         rvalid_in = 1'b1;
         ecnt_in   = ecnt_ff + 1'b1;
         if (acc_ff) begin
            gsum_in = sum_wide[SW] ? moetk_pkg::SUM_MAX : sum_wide[SW-1:0];
         end
      end
      if (cmd.loss_load) begin
         rvalid_in = 1'b1;
         ecount_in = '0;
         tcount_in = '0;
         gsum_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff    <= CW'(8);
         topk_ff   <= CW'(2);
         ecount_ff <= '0;
         tcount_ff <= '0;
         gsum_ff   <= '0;
         ecnt_ff   <= '0;
         acc_ff    <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         num_ff    <= num_in;
         topk_ff   <= topk_in;
         ecount_ff <= ecount_in;
         tcount_ff <= tcount_in;
         gsum_ff   <= gsum_in;
         ecnt_ff   <= ecnt_in;
         acc_ff    <= acc_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         list_ff[j] <= list_in[j];
      end
      if (cmd.mul) begin
         prod_ff <= NW'(e_eff) * NW'(gsum_ff);
      end
      if (cmd.emit_load) begin
         rkind_ff <= moetk_pkg::RES_GATE;
         ridx_ff  <= list_ff[0].idx;
         rgate_ff <= list_ff[0].prob;
         rloss_ff <= '0;
         rlast_ff <= st.emit_last;
      end else if (cmd.loss_load) begin
         rkind_ff <= moetk_pkg::RES_LOSS;
         ridx_ff  <= '0;
         rgate_ff <= '0;
         rloss_ff <= loss;
         rlast_ff <= 1'b1;
      end
   end

   moetk_div #(
      .NW (NW),
      .DW (TW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (tcount_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      st.token_done = ({1'b0, ecount_ff} + 1'b1) >= {1'b0, e_eff};
      st.emit_last  = ({1'b0, ecnt_ff} + 1'b1) == {1'b0, k_eff};
      st.out_free   = !rvalid_ff || rsp_ready;
      st.div_busy   = div_busy;
   end

   assign rsp_valid        = rvalid_ff;
   assign rsp_result_kind  = rkind_ff;
   assign rsp_expert_index = ridx_ff;
   assign rsp_gate_value   = rgate_ff;
   assign rsp_balance_loss = rloss_ff;
   assign rsp_last         = rlast_ff;

`ifndef ASSERT_OFF
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load || cmd.loss_load) |-> (!rvalid_ff || rsp_ready))
      else $error("result loaded over a pending transfer");
   a_ecount_range: assert property (@(posedge clock) disable iff (reset)
      ecount_ff < e_eff)
      else $error("expert count reached the expert total");
   a_tcount_cap: assert property (@(posedge clock) disable iff (reset)
      tcount_ff <= TW'(MAX_TOKENS))
      else $error("token count above its cap");
   a_loss_out: assert property (@(posedge clock) disable iff (reset)
      cmd.loss_load |=> (rvalid_ff && rkind_ff == moetk_pkg::RES_LOSS && rlast_ff
                         && tcount_ff == '0 && gsum_ff == '0))
      else $error("loss result or batch clear missing");
`endif

endmodule
`default_nettype wire

@@ rtl/moetk_ctrl.sv @@
`default_nettype none
module moetk_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_kind,
   output logic                       req_ready,
   input  wire moetk_pkg::status_type st,
   output moetk_pkg::cmd_type         cmd
);

   moetk_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= moetk_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         moetk_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == moetk_pkg::KIND_PROB) begin
                  cmd.insert = 1'b1;
                  if (st.token_done) begin
                     state_in = moetk_pkg::S_EMIT;
                  end
               end else begin
                  cmd.mul  = 1'b1;
                  state_in = moetk_pkg::S_DSTART;
               end
            end
         end
         moetk_pkg::S_EMIT: begin
            if (st.out_free) begin
               cmd.emit_load = 1'b1;
               if (st.emit_last) begin
                  state_in = moetk_pkg::S_IDLE;
               end
            end
         end
         moetk_pkg::S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = moetk_pkg::S_DIV;
         end
         moetk_pkg::S_DIV: begin
            if (!st.div_busy) begin
               state_in = moetk_pkg::S_LOSS;
            end
         end
         moetk_pkg::S_LOSS: begin
            if (st.out_free) begin
               cmd.loss_load = 1'b1;
               state_in      = moetk_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = moetk_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/moe_topk_gate_router_top.sv @@
`default_nettype none
// Probability item: accepted while idle; the insertion list updates at the accepting edge.
// Token end: top_k gate results follow, one per cycle while the output is taken;
// the first is loaded from S_EMIT once the output register is free.
// End of batch: the loss result follows a multiply, a 36-step divider run and a load.
// Reset (synchronous, active high) resets the CSRs, counts, sums, result valid and control;
// the insertion list, product, divider data and result fields are not cleared.
module moe_topk_gate_router_top #(
   parameter int MAX_EXPERTS = 64,
   parameter int MAX_TOKENS  = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   moetk_req_if.sink                             req_ch,
   moetk_rsp_if.source                           rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [moetk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [moetk_pkg::CFG_W-1:0]      csr_wdata
);

   moetk_pkg::cmd_type    cmd;
   moetk_pkg::status_type st;

   moetk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   moetk_dp #(
      .MAX_EXPERTS (MAX_EXPERTS),
      .MAX_TOKENS  (MAX_TOKENS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_probability  (req_ch.probability),
      .cmd              (cmd),
      .st               (st),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_result_kind  (rsp_ch.result_kind),
      .rsp_expert_index (rsp_ch.expert_index),
      .rsp_gate_value   (rsp_ch.gate_value),
      .rsp_balance_loss (rsp_ch.balance_loss),
      .rsp_last         (rsp_ch.last)
   );

endmodule
`default_nettype wire
